[design/fixed_chunk_pool_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the chunk pool allocator
// Shared same-cycle-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FCPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fcpa assertion failed");

// next-cycle implication, disabled during reset
`define FCPA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fcpa assertion failed");

`endif

[design/fcpa_pkg.sv]
// ----------------------------------------------------------------------------
// fcpa_pkg
// Constants, codes and types shared by the chunk pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpa_pkg;

    localparam int MAX_CHUNKS   = 64;
    localparam int HEADER_BYTES = 8;

    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 13;
    localparam int CCNT_W  = 7;
    localparam int IDX_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
    localparam int STR_W   = BYTES_W + 1;
    localparam int PROD_W  = CNT_W + STR_W;
    localparam int DIV_W   = STR_W + IDX_W;
    localparam int STEP_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [1:0] REG_CHUNK_BYTES = 2'd1;
    localparam logic [1:0] REG_CHUNK_COUNT = 2'd2;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_CHECK = 2'd2,
        K_BAD   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_MUL,
        S_ADDR,
        S_LIMIT,
        S_RANGE,
        S_DIV,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [STR_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [IDX_W-1:0]   quot;
        logic [DIV_W-1:0]   rem;
    } t_div_rsp;

endpackage

`default_nettype wire

[design/fcpa_div.sv]
// ----------------------------------------------------------------------------
// fcpa_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpa_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fcpa_pkg::t_div_req i_req,
    output fcpa_pkg::t_div_rsp      o_rsp
);
    import fcpa_pkg::*;

    logic               r_busy;
    logic [STEP_W-1:0]  r_step;
    logic [DIV_W-1:0]   r_rem;
    logic [STR_W-1:0]   r_den;
    logic [IDX_W-1:0]   r_quot;
    logic [DIV_W:0]     w_trial;

    assign w_trial = {1'b0, r_rem} - ((DIV_W + 1)'(r_den) << r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_step == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.dividend;
            r_den  <= i_req.divisor;
            r_quot <= '0;
            r_step <= STEP_W'(IDX_W - 1);
        end else if (r_busy) begin
            if (!w_trial[DIV_W]) begin
                r_rem          <= w_trial[DIV_W-1:0];
                r_quot[r_step] <= 1'b1;
            end
            r_step <= r_step - 1'b1;
        end
    end

    assign o_rsp.done = r_busy && (r_step == '0);
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

[design/fixed_chunk_pool_allocator.sv]
// Allocate: result registered through the pop, multiply and address states; free and
// check: limit, range, divide and check states, divide held until the divider is done;
// empty pool and unknown kind go straight to finish, out-of-range addresses after range.
// One item at a time, held by output stall: the next input beat is taken only after the
// result is handed to the output register.
// Synchronous active-low reset and writes to base, bytes or count rebuild the pool.
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator
// Fixed-size chunk pool with a LIFO free stack, address validation by an
// iterative divider and a shared multiplier for range and address sums.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_chunk_pool_allocator_defines.svh"

module fixed_chunk_pool_allocator (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_kind,
    input  wire logic [fcpa_pkg::ADDR_W-1:0] i_address,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [1:0]                     o_status,
    output logic [fcpa_pkg::ADDR_W-1:0]    o_data_address,
    output logic                           o_is_valid,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [fcpa_pkg::ADDR_W-1:0] i_cfg_data
);
    import fcpa_pkg::*;

    t_state              r_state, n_state;
    t_kind               r_kind;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_pool_base;
    logic [BYTES_W-1:0]  r_chunk_bytes;
    logic [CCNT_W-1:0]   r_chunk_count;
    logic                r_rebuild;

    logic [CNT_W-1:0]    r_free_cnt;
    logic [CNT_W-1:0]    r_min;
    logic [MAX_CHUNKS-1:0] r_marks;
    logic [IDX_W-1:0]    r_stack [MAX_CHUNKS];
    logic [IDX_W-1:0]    r_rd_data;

    logic [IDX_W-1:0]    r_idx;
    logic [PROD_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_off;
    logic                r_below;

    logic [1:0]          r_res_status;
    logic [ADDR_W-1:0]   r_res_data;
    logic                r_res_valid;

    logic                r_o_valid;
    logic [1:0]          r_o_status;
    logic [ADDR_W-1:0]   r_o_data;
    logic                r_o_is_valid;

    logic [CNT_W-1:0]    w_used;
    logic [STR_W-1:0]    w_stride;
    logic [CNT_W-1:0]    w_pos;
    logic [IDX_W-1:0]    w_pop_idx;
    logic [CNT_W-1:0]    w_mul_a;
    logic [PROD_W-1:0]   w_mul;
    logic                w_hit;
    logic                w_range_bad;
    logic                w_cfg_we;
    logic                w_accept;
    logic                w_out_free;
    logic                w_pop;
    logic                w_push;
    logic                w_div_start;
    logic                w_load_out;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    // ---- configuration, taken only between items
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_chunk_bytes <= BYTES_W'(64);
            r_chunk_count <= CCNT_W'(64);
            r_rebuild     <= 1'b1;
        end else begin
            r_rebuild <= 1'b0;
            if (w_cfg_we) begin
                unique case (i_cfg_index)
                    REG_POOL_BASE: begin
                        r_pool_base <= i_cfg_data;
                        r_rebuild   <= 1'b1;
                    end
                    REG_CHUNK_BYTES: begin
                        r_chunk_bytes <= i_cfg_data[BYTES_W-1:0];
                        r_rebuild     <= 1'b1;
                    end
                    REG_CHUNK_COUNT: begin
                        r_chunk_count <= i_cfg_data[CCNT_W-1:0];
                        r_rebuild     <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign w_used   = (32'(r_chunk_count) > 32'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
                                                           : CNT_W'(r_chunk_count);
    assign w_stride = STR_W'(r_chunk_bytes) + STR_W'(HEADER_BYTES);

    // ---- handshakes
    assign o_in_stall = (r_state != S_IDLE) || r_rebuild || i_cfg_valid;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_o_valid || !i_out_stall;

    // ---- shared multiplier: index times stride, or count times stride
    assign w_mul_a = (r_kind == K_ALLOC) ? CNT_W'(r_idx) : w_used;
    assign w_mul   = PROD_W'(w_mul_a) * PROD_W'(w_stride);

    // positions below the lowest fill since rebuild still hold their own index
    assign w_pos     = r_free_cnt - 1'b1;
    assign w_pop_idx = (w_pos < r_min) ? w_pos[IDX_W-1:0] : r_rd_data;

    assign w_range_bad = r_below || (r_off >= ADDR_W'(r_prod));
    assign w_hit       = (w_div_rsp.rem == DIV_W'(HEADER_BYTES)) && r_marks[w_div_rsp.quot];

    // ---- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_kind'(i_kind)) inside
                        K_ALLOC:         n_state = (r_free_cnt == '0) ? S_FINISH : S_POP;
                        K_FREE, K_CHECK: n_state = S_LIMIT;
                        default:         n_state = S_FINISH;
                    endcase
                end
            end
            S_POP:    n_state = S_MUL;
            S_MUL:    n_state = S_ADDR;
            S_ADDR:   n_state = S_FINISH;
            S_LIMIT:  n_state = S_RANGE;
            S_RANGE:  n_state = w_range_bad ? S_FINISH : S_DIV;
            S_DIV:    n_state = w_div_rsp.done ? S_CHECK : S_DIV;
            S_CHECK:  n_state = S_FINISH;
            S_FINISH: n_state = w_out_free ? S_IDLE : S_FINISH;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---- control strobes
    always_comb begin
        w_pop       = 1'b0;
        w_push      = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_POP:    w_pop       = 1'b1;
            S_RANGE:  w_div_start = !w_range_bad;
            S_CHECK:  w_push      = (r_kind == K_FREE) && w_hit
                                    && (r_free_cnt < CNT_W'(MAX_CHUNKS));
            S_FINISH: w_load_out  = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- free stack memory
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[r_free_cnt[IDX_W-1:0]] <= w_div_rsp.quot;
        end
        r_rd_data <= r_stack[w_pos[IDX_W-1:0]];
    end

    // ---- pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks    <= '0;
            r_free_cnt <= '0;
            r_min      <= '0;
        end else if (r_rebuild) begin
            r_marks    <= '0;
            r_free_cnt <= w_used;
            r_min      <= w_used;
        end else if (w_pop) begin
            r_marks[w_pop_idx] <= 1'b1;
            r_free_cnt         <= w_pos;
            if (w_pos < r_min) begin
                r_min <= w_pos;
            end
        end else if (w_push) begin
            r_marks[w_div_rsp.quot] <= 1'b0;
            r_free_cnt              <= r_free_cnt + 1'b1;
        end
    end

    // ---- item datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind       <= t_kind'(i_kind);
            r_addr       <= i_address;
            r_res_data   <= '0;
            r_res_valid  <= 1'b0;
            r_res_status <= ((t_kind'(i_kind) == K_ALLOC) && (r_free_cnt == '0)) ? ST_EMPTY
                                                                                 : ST_INVALID;
        end
        unique case (r_state)
            S_POP: r_idx <= w_pop_idx;
            S_MUL: r_prod <= w_mul;
            S_ADDR: begin
                r_res_data   <= r_pool_base + ADDR_W'(r_prod) + ADDR_W'(HEADER_BYTES);
                r_res_status <= ST_OK;
            end
            S_LIMIT: begin
                r_off   <= r_addr - r_pool_base;
                r_below <= r_addr < r_pool_base;
                r_prod  <= w_mul;
            end
            S_CHECK: begin
                if (w_hit && ((r_kind == K_CHECK) || w_push)) begin
                    r_res_status <= ST_OK;
                    r_res_valid  <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_div_req.start    = w_div_start;
    assign w_div_req.dividend = r_off[DIV_W-1:0];
    assign w_div_req.divisor  = w_stride;

    fcpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_status   <= r_res_status;
            r_o_data     <= r_res_data;
            r_o_is_valid <= r_res_valid;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_data_address = r_o_data;
    assign o_is_valid     = r_o_is_valid;

    // ---- assertions
    `FCPA_ASSERT_IMP(a_free_le_used, !r_rebuild, r_free_cnt <= w_used)
    `FCPA_ASSERT_NXT(a_accept_busy, w_accept, o_in_stall)
    `FCPA_ASSERT_IMP(a_valid_means_ok, o_out_valid && o_is_valid, o_status == ST_OK)
    `FCPA_ASSERT_IMP(a_div_done_in_div, w_div_rsp.done, r_state == S_DIV)

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - chunk pool allocator testbench
// Drives allocate, free and check beats against a behavioural model of the
// LIFO chunk pool, under random source gaps and sink stalls, across several
// register settings. A directed table comes first, then random phases.
// ----------------------------------------------------------------------------
module tb;
    import fcpa_pkg::*;

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 130;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] daddr;
        logic        is_valid;
    } t_pool_rsp;

    typedef struct {
        bit          cfg;
        logic [1:0]  op;
        logic [31:0] val;
        bit          typed;
        t_pool_rsp   rsp;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_address = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [31:0] o_data_address;
    logic        o_is_valid;
    logic        o_cfg_ready;

    fixed_chunk_pool_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_data_address (o_data_address),
        .o_is_valid     (o_is_valid),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pool model state
    logic [31:0]      pm_base;
    logic [12:0]      pm_bytes;
    logic [6:0]       pm_count;
    logic [IDX_W-1:0] pm_stack [MAX_CHUNKS];
    int               pm_fcount;
    bit [MAX_CHUNKS-1:0] pm_mark;
    logic [31:0]      live_addrs [$];

    t_pool_rsp rsp_pending [$];
    t_dir_row  dir_rows [$];
    int        mism = 0;
    int        idle_pct = 25;
    int        hold_reqs = 0;

    function automatic int pool_used();
        return (pm_count > MAX_CHUNKS) ? MAX_CHUNKS : int'(pm_count);
    endfunction

    function automatic longint unsigned pool_stride();
        return longint'(pm_bytes) + HEADER_BYTES;
    endfunction

    function automatic logic [31:0] chunk_data_addr(input int idx);
        longint unsigned a;
        a = longint'(pm_base) + longint'(idx) * pool_stride() + HEADER_BYTES;
        return a[31:0];
    endfunction

    function automatic void pool_rebuild();
        int n;
        n = pool_used();
        pm_mark = '0;
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            pm_stack[i] = (i < n) ? IDX_W'(i) : '0;
        end
        pm_fcount = n;
        live_addrs.delete();
    endfunction

    function automatic void pool_setreg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_POOL_BASE:   pm_base = val;
            REG_CHUNK_BYTES: pm_bytes = val[12:0];
            REG_CHUNK_COUNT: pm_count = val[6:0];
            default: return;
        endcase
        pool_rebuild();
    endfunction

    function automatic bit chunk_lookup(input logic [31:0] addr, output int idx);
        longint unsigned off;
        longint unsigned q;
        idx = 0;
        if (addr < pm_base)
            return 0;
        off = longint'(addr - pm_base);
        if (off >= longint'(pool_used()) * pool_stride())
            return 0;
        if (off % pool_stride() != HEADER_BYTES)
            return 0;
        q = off / pool_stride();
        if (q >= MAX_CHUNKS || !pm_mark[q])
            return 0;
        idx = int'(q);
        return 1;
    endfunction

    function automatic t_pool_rsp pool_apply(input t_kind kind, input logic [31:0] addr);
        t_pool_rsp r;
        int idx;
        r.status = ST_INVALID;
        r.daddr = '0;
        r.is_valid = 1'b0;
        case (kind)
            K_ALLOC: begin
                if (pm_fcount == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pm_fcount--;
                    idx = int'(pm_stack[pm_fcount]);
                    pm_mark[idx] = 1'b1;
                    r.status = ST_OK;
                    r.daddr = chunk_data_addr(idx);
                    live_addrs.push_back(r.daddr);
                end
            end
            K_FREE: begin
                if (chunk_lookup(addr, idx) && pm_fcount < MAX_CHUNKS) begin
                    pm_mark[idx] = 1'b0;
                    pm_stack[pm_fcount] = IDX_W'(idx);
                    pm_fcount++;
                    r.status = ST_OK;
                    r.is_valid = 1'b1;
                    for (int i = 0; i < live_addrs.size(); i++) begin
                        if (live_addrs[i] == addr) begin
                            live_addrs.delete(i);
                            break;
                        end
                    end
                end
            end
            K_CHECK: begin
                if (chunk_lookup(addr, idx)) begin
                    r.status = ST_OK;
                    r.is_valid = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void dir_row(input bit cfg, input logic [1:0] op,
                                    input logic [31:0] val, input bit typed = 0,
                                    input logic [1:0] st = ST_OK,
                                    input logic [31:0] da = '0, input bit va = 0);
        t_dir_row row;
        row.cfg = cfg;
        row.op = op;
        row.val = val;
        row.typed = typed;
        row.rsp = '{status: st, daddr: da, is_valid: va};
        dir_rows.push_back(row);
    endfunction

    task automatic pool_send(input logic [1:0] kind, input logic [31:0] addr,
                             input bit typed, input t_pool_rsp typed_rsp);
        t_pool_rsp r;
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 17);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        r = pool_apply(t_kind'(kind), addr);
        rsp_pending.push_back(typed ? typed_rsp : r);
    endtask

    task automatic pool_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pool_setreg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sink stalls: random bursts, plus one long hold on request
    initial begin
        int burst_left;
        int hold_left;
        int holds_served;
        burst_left = 0;
        hold_left = 0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (idle_pct == 0) begin
                burst_left = 0;
                i_out_stall <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < idle_pct / 2) begin
                burst_left = $urandom_range(1, 17) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_pool_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_pending.size() == 0) begin
                mism++;
                if (mism <= 10)
                    $display("tb: unexpected result beat st=%0d addr=%h ok=%0b",
                             o_status, o_data_address, o_is_valid);
            end else begin
                want = rsp_pending.pop_front();
                if (o_status !== want.status || o_data_address !== want.daddr ||
                    o_is_valid !== want.is_valid) begin
                    mism++;
                    if (mism <= 10)
                        $display("tb: mismatch want st=%0d addr=%h ok=%0b got st=%0d addr=%h ok=%0b",
                                 want.status, want.daddr, want.is_valid,
                                 o_status, o_data_address, o_is_valid);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: watchdog expired");
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] val;
        t_pool_rsp   none;
        int          sel;
        none = '0;
        pm_base = '0;
        pm_bytes = 13'd64;
        pm_count = 7'd64;
        pool_rebuild();

        // defaults: stride 72, top of stack is chunk 63
        dir_row(0, K_ALLOC, 32'hFFFF_FFFF, 1, ST_OK, 32'd4544, 0);
        dir_row(0, K_ALLOC, 32'd0, 1, ST_OK, 32'd4472, 0);
        dir_row(0, K_CHECK, 32'd4544, 1, ST_OK, 32'd0, 1);
        dir_row(0, K_CHECK, 32'd4473, 1, ST_INVALID);
        dir_row(0, K_CHECK, 32'd0, 1, ST_INVALID);
        dir_row(0, K_CHECK, 32'd8, 1, ST_INVALID);
        dir_row(0, K_CHECK, 32'd4616, 1, ST_INVALID);
        dir_row(0, K_CHECK, 32'hFFFF_FFFF, 1, ST_INVALID);
        dir_row(0, K_BAD, 32'd4472, 1, ST_INVALID);
        dir_row(0, K_FREE, 32'd4544, 1, ST_OK, 32'd0, 1);
        dir_row(0, K_FREE, 32'd4544, 1, ST_INVALID);
        dir_row(0, K_FREE, 32'd4472, 1, ST_OK, 32'd0, 1);
        dir_row(0, K_ALLOC, 32'd0, 1, ST_OK, 32'd4472, 0);
        // empty pool
        dir_row(1, REG_CHUNK_COUNT, 32'd0);
        dir_row(0, K_ALLOC, 32'd0, 1, ST_EMPTY);
        dir_row(0, K_FREE, 32'd4472, 1, ST_INVALID);
        // saturated count, zero data bytes: the last data address sits at the bound
        dir_row(1, REG_CHUNK_COUNT, 32'd127);
        dir_row(1, REG_CHUNK_BYTES, 32'd0);
        dir_row(0, K_ALLOC, 32'd0, 1, ST_OK, 32'h0000_0200, 0);
        dir_row(0, K_FREE, 32'h0000_0200, 1, ST_INVALID);
        // data address wraps below the base
        dir_row(1, REG_POOL_BASE, 32'hFFFF_FF00);
        dir_row(0, K_ALLOC, 32'd0, 1, ST_OK, 32'h0000_0100, 0);
        dir_row(0, K_FREE, 32'h0000_0100, 1, ST_INVALID);
        dir_row(0, K_CHECK, 32'hFFFF_FF08);
        dir_row(1, REG_CHUNK_BYTES, 32'h0000_1FFF);
        dir_row(0, K_ALLOC, 32'd0);
        // unused index leaves the pool as it is
        dir_row(1, REG_NONE, 32'hFFFF_FFFF);
        dir_row(0, K_ALLOC, 32'd0);
        // single chunk
        dir_row(1, REG_CHUNK_COUNT, 32'd1);
        dir_row(1, REG_POOL_BASE, 32'd0);
        dir_row(0, K_ALLOC, 32'd0, 1, ST_OK, 32'd8, 0);
        dir_row(0, K_ALLOC, 32'd0, 1, ST_EMPTY);
        dir_row(0, K_CHECK, 32'd8, 1, ST_OK, 32'd0, 1);
        dir_row(0, K_FREE, 32'd8, 1, ST_OK, 32'd0, 1);
        dir_row(0, K_ALLOC, 32'd0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[j]) begin
            if (dir_rows[j].cfg) begin
                pool_drain();
                reg_write(dir_rows[j].op, dir_rows[j].val);
            end else begin
                pool_send(dir_rows[j].op, dir_rows[j].val, dir_rows[j].typed, dir_rows[j].rsp);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            pool_drain();
            idle_pct = (p == 4 || p == PHASES - 1) ? 0 : $urandom_range(10, 40);
            case ($urandom_range(0, 4))
                0: val = '0;
                1: val = '1;
                2: val = 32'hFFFF_F000 | $urandom_range(0, 32'hFFF);
                default: val = $urandom;
            endcase
            reg_write(REG_POOL_BASE, val);
            case ($urandom_range(0, 5))
                0: val = 32'd0;
                1: val = 32'd4096;
                2: val = 32'h1FFF;
                3: val = 32'd1;
                default: val = $urandom_range(2, 200);
            endcase
            if ($urandom_range(0, 1))
                val = val | ($urandom & 32'hFFFF_E000);
            reg_write(REG_CHUNK_BYTES, val);
            case ($urandom_range(0, 9)) inside
                0: val = 32'd0;
                1: val = 32'd1;
                2: val = $urandom_range(65, 127);
                3, 4: val = 32'd64;
                default: val = $urandom_range(2, 63);
            endcase
            if ($urandom_range(0, 1))
                val = val | ($urandom & 32'hFFFF_FF80);
            reg_write(REG_CHUNK_COUNT, val);
            if ($urandom_range(0, 3) == 0)
                reg_write(REG_NONE, $urandom);
            if (p == 1)
                hold_reqs++;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                addr = $urandom;
                if (sel < 40) begin
                    kind = K_ALLOC;
                end else if (sel < 82) begin
                    kind = (sel < 70) ? K_FREE : K_CHECK;
                    if (live_addrs.size() != 0 && $urandom_range(0, 3) != 0)
                        addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
                    else
                        addr = chunk_data_addr($urandom_range(0, pool_used()));
                end else if (sel < 94) begin
                    kind = $urandom_range(0, 1) ? K_FREE : K_CHECK;
                    addr = chunk_data_addr($urandom_range(0, pool_used()));
                    case ($urandom_range(0, 3))
                        0: addr = addr + 32'd1;
                        1: addr = addr - 32'd1;
                        2: addr = addr - HEADER_BYTES;
                        default: addr = addr + $urandom_range(1, 16);
                    endcase
                end else begin
                    kind = $urandom_range(0, 3);
                end
                pool_send(kind, addr, 0, none);
            end
        end

        pool_drain();
        repeat (20) @(posedge i_clk);
        if (mism == 0 && rsp_pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
